// ===== hdl/sstf_pkg.sv =====
// Shared constants, types and datapath command codes for the SSTF scheduler.
// No dependencies; every other file in hdl/ refers to this package.
package sstf_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TRACK_BITS  = 16;
  localparam int TAG_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef struct packed {
    logic [TRACK_BITS-1:0] track;
    logic [TAG_W-1:0]      tag;
    logic                  wr;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_FETCH,
    OP_SHIFT,
    OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    logic mode;
    logic empty;
    logic scan_done;
    logic shift_done;
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== hdl/sstf_ifs.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on sstf_pkg for field widths.
interface sstf_req_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [sstf_pkg::TRACK_BITS-1:0] track;
  logic [sstf_pkg::TAG_W-1:0]      request_tag;
  logic                            is_write;

  modport source (output valid, mode, track, request_tag, is_write, input ready);
  modport sink   (input valid, mode, track, request_tag, is_write, output ready);
endinterface

interface sstf_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [sstf_pkg::STATUS_W-1:0]   status;
  logic [sstf_pkg::TRACK_BITS-1:0] out_track;
  logic [sstf_pkg::TAG_W-1:0]      out_tag;
  logic                            out_is_write;
  logic [sstf_pkg::CNT_W-1:0]      occupancy;

  modport source (output valid, status, out_track, out_tag, out_is_write, occupancy,
                  input ready);
  modport sink   (input valid, status, out_track, out_tag, out_is_write, occupancy,
                  output ready);
endinterface

// ===== hdl/sstf_datapath.sv =====
// Request table, seek-distance scan, compaction shift and response register.
// Driven by sstf_ctrl through sstf_pkg::dp_op_t commands; depends on sstf_pkg.
module sstf_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sstf_pkg::dp_op_t                op,
  output sstf_pkg::dp_sts_t               sts,
  input  logic                            in_mode,
  input  logic [sstf_pkg::TRACK_BITS-1:0] in_track,
  input  logic [sstf_pkg::TAG_W-1:0]      in_tag,
  input  logic                            in_wr,
  output logic                            out_vld,
  input  logic                            out_rdy,
  output logic [sstf_pkg::STATUS_W-1:0]   out_status,
  output logic [sstf_pkg::TRACK_BITS-1:0] out_track,
  output logic [sstf_pkg::TAG_W-1:0]      out_tag,
  output logic                            out_wr,
  output logic [sstf_pkg::CNT_W-1:0]      out_occ
);

  localparam int IW = sstf_pkg::IDX_W;
  localparam int CW = sstf_pkg::CNT_W;
  localparam int TW = sstf_pkg::TRACK_BITS;

  sstf_pkg::entry_t mem [sstf_pkg::QUEUE_DEPTH];
  sstf_pkg::entry_t rd_data;
  sstf_pkg::entry_t item;
  sstf_pkg::entry_t sel;
  logic             mode;
  logic [CW-1:0]    cnt;
  logic [TW-1:0]    head;
  logic [CW-1:0]    ptr;
  logic             cmp_vld;
  logic [IW-1:0]    cmp_idx;
  logic [IW-1:0]    best_idx;
  logic [TW-1:0]    best_dist;
  logic             best_first;
  logic             sel_pend;
  logic             wr_pend;
  logic [IW-1:0]    wr_idx;

  logic [IW-1:0]    rd_addr;
  logic             issue;
  logic             full;
  logic [TW-1:0]    seek_gap;

  assign issue    = ptr < cnt;
  assign full     = cnt == CW'(sstf_pkg::QUEUE_DEPTH);
  assign seek_gap = (head >= rd_data.track) ? (head - rd_data.track) : (rd_data.track - head);

  always_comb begin
    case (op)
      sstf_pkg::OP_FETCH: rd_addr = best_idx;
      default:            rd_addr = ptr[IW-1:0];
    endcase
  end

  assign sts.mode       = mode;
  assign sts.empty      = cnt == '0;
  assign sts.scan_done  = !issue && !cmp_vld;
  assign sts.shift_done = !issue && !wr_pend && !sel_pend;
  assign sts.out_busy   = out_vld && !out_rdy;

  // table storage: one read port, one write port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_pend) begin
      mem[wr_idx] <= rd_data;
    end else if (op == sstf_pkg::OP_COMMIT && mode == sstf_pkg::MODE_ENQ && !full) begin
      mem[cnt[IW-1:0]] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      head       <= '0;
      cmp_vld    <= 1'b0;
      sel_pend   <= 1'b0;
      wr_pend    <= 1'b0;
      out_vld    <= 1'b0;
      best_first <= 1'b1;
    end else begin
      cmp_vld  <= (op == sstf_pkg::OP_SCAN) && issue;
      sel_pend <= op == sstf_pkg::OP_FETCH;
      wr_pend  <= (op == sstf_pkg::OP_SHIFT) && issue;
      if (out_vld && out_rdy && op != sstf_pkg::OP_COMMIT) begin
        out_vld <= 1'b0;
      end
      case (op)
        sstf_pkg::OP_LATCH: begin
          mode       <= in_mode;
          item.track <= in_track;
          item.tag   <= in_tag;
          item.wr    <= in_wr;
        end
        sstf_pkg::OP_SCAN_INIT: begin
          ptr        <= '0;
          best_idx   <= '0;
          best_first <= 1'b1;
        end
        sstf_pkg::OP_SCAN: begin
          if (issue) begin
            cmp_idx <= ptr[IW-1:0];
            ptr     <= ptr + CW'(1);
          end
        end
        sstf_pkg::OP_FETCH: begin
          ptr <= CW'(best_idx) + CW'(1);
        end
        sstf_pkg::OP_SHIFT: begin
          if (issue) begin
            wr_idx <= ptr[IW-1:0] - IW'(1);
            ptr    <= ptr + CW'(1);
          end
        end
        sstf_pkg::OP_COMMIT: begin
          out_vld <= 1'b1;
          if (mode == sstf_pkg::MODE_ENQ) begin
            out_track <= '0;
            out_tag   <= '0;
            out_wr    <= 1'b0;
            if (full) begin
              out_status <= sstf_pkg::ST_FULL;
              out_occ    <= cnt;
            end else begin
              out_status <= sstf_pkg::ST_OK;
              out_occ    <= cnt + CW'(1);
              cnt        <= cnt + CW'(1);
            end
          end else if (cnt == '0) begin
            out_status <= sstf_pkg::ST_EMPTY;
            out_track  <= '0;
            out_tag    <= '0;
            out_wr     <= 1'b0;
            out_occ    <= '0;
          end else begin
            out_status <= sstf_pkg::ST_OK;
            out_track  <= sel.track;
            out_tag    <= sel.tag;
            out_wr     <= sel.wr;
            out_occ    <= cnt - CW'(1);
            cnt        <= cnt - CW'(1);
            head       <= sel.track;
          end
        end
        default: begin
        end
      endcase
      // strict less-than keeps the earliest entry on equal distance
      if (cmp_vld && (best_first || seek_gap < best_dist)) begin
        best_idx   <= cmp_idx;
        best_dist  <= seek_gap;
        best_first <= 1'b0;
      end
      if (sel_pend) begin
        sel <= rd_data;
      end
    end
  end

endmodule

// ===== hdl/sstf_ctrl.sv =====
// Sequencer for the SSTF scheduler: latch, scan, fetch, shift, commit.
// Issues sstf_pkg::dp_op_t commands to sstf_datapath; depends on sstf_pkg.
module sstf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  output logic               in_rdy,
  input  sstf_pkg::dp_sts_t  sts,
  output sstf_pkg::dp_op_t   op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FETCH,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    op         = sstf_pkg::OP_NOP;
    case (state)
      S_IDLE: begin
        if (in_vld && in_rdy) begin
          op         = sstf_pkg::OP_LATCH;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.mode == sstf_pkg::MODE_DEQ && !sts.empty) begin
          op         = sstf_pkg::OP_SCAN_INIT;
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_FETCH;
        end else begin
          op = sstf_pkg::OP_SCAN;
        end
      end
      S_FETCH: begin
        op         = sstf_pkg::OP_FETCH;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          state_next = S_FINISH;
        end else begin
          op = sstf_pkg::OP_SHIFT;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          op         = sstf_pkg::OP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_rdy <= 1'b0;
    end else begin
      state  <= state_next;
      in_rdy <= state_next == S_IDLE;
    end
  end

endmodule

// ===== hdl/sstf_disk_request_scheduler_core.sv =====
// Top level of the shortest-seek-time-first disk request scheduler.
// Depends on sstf_pkg, sstf_ifs (channels), sstf_ctrl and sstf_datapath.
//
// Usage:
//   req channel: one transaction per command. mode 0 appends a request
//   (track, request_tag, is_write) to the table; mode 1 removes the pending
//   request nearest the head position (earliest arrival wins a tie) and
//   moves the head to its track.
//   rsp channel: exactly one transaction per request: status, the removed
//   request (zero on enqueue or empty), and the occupancy after the command.
// Throughput: one command at a time. Enqueue and empty dequeue pass from
//   acceptance through the execute and finish states to response valid. A
//   dequeue also scans the held entries, fetches the winner and shifts the
//   entries behind it down, one table read per cycle for the scan and one per
//   cycle to close the gap through the single read / single write table port.
// Reset: table empty, head at track 0; req.ready rises the cycle after reset is released.
// Stall: a pending response sits in its output register; a new command is
//   accepted meanwhile, and its result waits until the old one is taken.
module sstf_disk_request_scheduler_core (
  input logic        clk,
  input logic        rst,
  sstf_req_if.sink   req,
  sstf_rsp_if.source rsp
);

  sstf_pkg::dp_op_t  op;
  sstf_pkg::dp_sts_t sts;

  sstf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in_vld (req.valid),
    .in_rdy (req.ready),
    .sts    (sts),
    .op     (op)
  );

  sstf_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .sts        (sts),
    .in_mode    (req.mode),
    .in_track   (req.track),
    .in_tag     (req.request_tag),
    .in_wr      (req.is_write),
    .out_vld    (rsp.valid),
    .out_rdy    (rsp.ready),
    .out_status (rsp.status),
    .out_track  (rsp.out_track),
    .out_tag    (rsp.out_tag),
    .out_wr     (rsp.out_is_write),
    .out_occ    (rsp.occupancy)
  );

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.occupancy <= sstf_pkg::CNT_W'(sstf_pkg::QUEUE_DEPTH))
    else $error("occupancy above table depth");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == sstf_pkg::ST_FULL
      |-> rsp.occupancy == sstf_pkg::CNT_W'(sstf_pkg::QUEUE_DEPTH))
    else $error("drop reported with table not full");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == sstf_pkg::ST_EMPTY
      |-> rsp.occupancy == '0 && rsp.out_track == '0 && rsp.out_tag == '0)
    else $error("empty status with nonzero fields");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second transaction accepted while busy");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for sstf_disk_request_scheduler_core: a directed table, then random
// enqueue/dequeue traffic. Pinned directed rows are checked against their fixed expected results,
// every other result against a shortest-seek predictor. Depends on sstf_pkg and the channel interfaces in sstf_ifs.
module tb;

  localparam int QUEUE_DEPTH = sstf_pkg::QUEUE_DEPTH;
  localparam int TRACK_BITS  = sstf_pkg::TRACK_BITS;
  localparam int TAG_W       = sstf_pkg::TAG_W;
  localparam int STATUS_W    = sstf_pkg::STATUS_W;
  localparam int CNT_W       = sstf_pkg::CNT_W;

  localparam logic MODE_ENQ = sstf_pkg::MODE_ENQ;
  localparam logic MODE_DEQ = sstf_pkg::MODE_DEQ;

  localparam logic [STATUS_W-1:0] ST_OK    = sstf_pkg::ST_OK;
  localparam logic [STATUS_W-1:0] ST_EMPTY = sstf_pkg::ST_EMPTY;
  localparam logic [STATUS_W-1:0] ST_FULL  = sstf_pkg::ST_FULL;

  typedef sstf_pkg::entry_t entry_t;

  localparam int MAX_GAP        = 19;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * QUEUE_DEPTH + 16;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 60;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic                  mode;
    logic [TRACK_BITS-1:0] track;
    logic [TAG_W-1:0]      tag;
    logic                  wr;
  } sched_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [TRACK_BITS-1:0] track;
    logic [TAG_W-1:0]      tag;
    logic                  wr;
    logic [CNT_W-1:0]      occupancy;
  } sched_rsp_t;

  typedef struct packed {
    logic       on;
    sched_rsp_t res;
  } pin_t;

  typedef struct packed {
    sched_cmd_t cmd;
    pin_t       pin;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sstf_req_if req_ch();
  sstf_rsp_if rsp_ch();

  sstf_disk_request_scheduler_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  entry_t                pending_q[$];
  logic [TRACK_BITS-1:0] head_track = '0;

  sched_rsp_t due_rsp_q[$];
  pin_t       pin_q[$];
  dir_row_t   dir_rows[$];

  int sent_count  = 0;
  int rsp_count   = 0;
  int errors      = 0;
  int n_enq       = 0;
  int n_deq       = 0;
  int n_full      = 0;
  int n_empty     = 0;
  int peak_occ    = 0;

  bit idle_on   = 1'b0;
  int hold_len  = 0;
  int rsp_wait  = 0;
  bit rsp_taken = 1'b0;
  int quiet_cycles = 0;

  function automatic sched_rsp_t schedule_next(input sched_cmd_t c);
    sched_rsp_t r;
    entry_t     e;
    int         best;
    int         best_dist;
    int         d;
    r = '0;
    if (c.mode == MODE_ENQ) begin
      n_enq++;
      if (pending_q.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        e.track = c.track;
        e.tag   = c.tag;
        e.wr    = c.wr;
        pending_q.push_back(e);
        r.status = ST_OK;
      end
    end else begin
      n_deq++;
      if (pending_q.size() == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        best = 0;
        best_dist = 0;
        for (int i = 0; i < pending_q.size(); i++) begin
          d = int'(head_track) - int'(pending_q[i].track);
          if (d < 0) d = -d;
          // strict compare keeps the earliest arrival on a tie
          if (i == 0 || d < best_dist) begin
            best = i;
            best_dist = d;
          end
        end
        r.status = ST_OK;
        r.track  = pending_q[best].track;
        r.tag    = pending_q[best].tag;
        r.wr     = pending_q[best].wr;
        head_track = pending_q[best].track;
        pending_q.delete(best);
      end
    end
    r.occupancy = CNT_W'(pending_q.size());
    if (pending_q.size() > peak_occ) peak_occ = pending_q.size();
    return r;
  endfunction

  // transaction monitor and checker
  always @(posedge clk) begin
    sched_cmd_t c;
    sched_rsp_t pred;
    sched_rsp_t got;
    sched_rsp_t want;
    pin_t       pin;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        c.mode  = req_ch.mode;
        c.track = req_ch.track;
        c.tag   = req_ch.request_tag;
        c.wr    = req_ch.is_write;
        pred = schedule_next(c);
        pin = '0;
        if (pin_q.size() > 0) pin = pin_q.pop_front();
        due_rsp_q.push_back(pin.on ? pin.res : pred);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status    = rsp_ch.status;
        got.track     = rsp_ch.out_track;
        got.tag       = rsp_ch.out_tag;
        got.wr        = rsp_ch.out_is_write;
        got.occupancy = rsp_ch.occupancy;
        rsp_count++;
        rsp_taken = 1'b1;
        if (due_rsp_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result: status=%0d track=%h tag=%h wr=%b occ=%0d",
                     got.status, got.track, got.tag, got.wr, got.occupancy);
        end else begin
          want = due_rsp_q.pop_front();
          if (got.status !== want.status || got.track !== want.track ||
              got.tag !== want.tag || got.wr !== want.wr ||
              got.occupancy !== want.occupancy) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("mismatch #%0d: exp status=%0d track=%h tag=%h wr=%b occ=%0d",
                       rsp_count, want.status, want.track, want.tag, want.wr,
                       want.occupancy);
              $display("              got status=%0d track=%h tag=%h wr=%b occ=%0d",
                       got.status, got.track, got.tag, got.wr, got.occupancy);
            end
          end
        end
      end
    end
  end

  // response side backpressure
  always @(negedge clk) begin
    if (hold_len > 0) begin
      rsp_wait = hold_len;
      hold_len = 0;
    end else if (rsp_taken) begin
      rsp_wait = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end
    rsp_taken = 1'b0;
    if (rsp_wait > 0) begin
      rsp_ch.ready = 1'b0;
      rsp_wait--;
    end else begin
      rsp_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input sched_cmd_t c, input pin_t pin, input int gap);
    pin_q.push_back(pin);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.mode        = c.mode;
    req_ch.track       = c.track;
    req_ch.request_tag = c.tag;
    req_ch.is_write    = c.wr;
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
  endtask

  task automatic add_row(input logic mode, input logic [TRACK_BITS-1:0] trk,
                         input logic [TAG_W-1:0] tag, input logic wr, input logic pinned,
                         input logic [STATUS_W-1:0] st, input logic [TRACK_BITS-1:0] otrk,
                         input logic [TAG_W-1:0] otag, input logic owr,
                         input int occ);
    dir_row_t row;
    row.cmd           = '{mode, trk, tag, wr};
    row.pin.on        = pinned;
    row.pin.res       = '{st, otrk, otag, owr, CNT_W'(occ)};
    dir_rows.push_back(row);
  endtask

  function automatic logic [TRACK_BITS-1:0] pick_track(input logic [TRACK_BITS-1:0] base);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel <= 3) return TRACK_BITS'($urandom_range(0, (1 << TRACK_BITS) - 1));
    // cluster near a base so equal seek distances come up often
    return base + TRACK_BITS'($urandom_range(0, 6)) - TRACK_BITS'(3);
  endfunction

  initial begin
    sched_cmd_t            c;
    pin_t                  no_pin;
    logic [TRACK_BITS-1:0] base;
    int                    enq_pct;
    int                    gap;

    req_ch.valid       = 1'b0;
    req_ch.mode        = MODE_ENQ;
    req_ch.track       = '0;
    req_ch.request_tag = '0;
    req_ch.is_write    = 1'b0;
    rsp_ch.ready       = 1'b0;
    no_pin             = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    add_row(MODE_DEQ, 16'h0000, 8'h00, 1'b0, 1'b1, ST_EMPTY, 16'h0000, 8'h00, 1'b0, 0);
    add_row(MODE_ENQ, 16'hFFFF, 8'hFF, 1'b1, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 1);
    add_row(MODE_DEQ, 16'h0000, 8'h00, 1'b0, 1'b1, ST_OK,    16'hFFFF, 8'hFF, 1'b1, 0);
    add_row(MODE_DEQ, 16'hFFFF, 8'hFF, 1'b1, 1'b1, ST_EMPTY, 16'h0000, 8'h00, 1'b0, 0);
    add_row(MODE_ENQ, 16'h8000, 8'h10, 1'b0, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 1);
    add_row(MODE_ENQ, 16'hFFFD, 8'h01, 1'b1, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 2);
    add_row(MODE_ENQ, 16'h0000, 8'h00, 1'b0, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 3);
    add_row(MODE_ENQ, 16'hFFFE, 8'h02, 1'b1, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 4);
    add_row(MODE_ENQ, 16'h0001, 8'h03, 1'b0, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 5);
    add_row(MODE_ENQ, 16'hFFFF, 8'h05, 1'b1, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 6);
    add_row(MODE_ENQ, 16'h1000, 8'h06, 1'b0, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 7);
    add_row(MODE_ENQ, 16'h1000, 8'h07, 1'b1, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 8);
    add_row(MODE_ENQ, 16'h0F00, 8'h08, 1'b0, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 9);
    add_row(MODE_ENQ, 16'h1100, 8'h09, 1'b1, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 10);
    add_row(MODE_ENQ, 16'h7FFF, 8'h0A, 1'b0, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 11);
    add_row(MODE_ENQ, 16'h00FF, 8'h0B, 1'b1, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 12);
    add_row(MODE_ENQ, 16'hAAAA, 8'h0C, 1'b0, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 13);
    add_row(MODE_ENQ, 16'h5555, 8'h0D, 1'b1, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 14);
    add_row(MODE_ENQ, 16'hFFFD, 8'h0E, 1'b0, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 15);
    add_row(MODE_ENQ, 16'h0002, 8'hFF, 1'b1, 1'b1, ST_OK,    16'h0000, 8'h00, 1'b0, 16);
    add_row(MODE_ENQ, 16'h1234, 8'hAB, 1'b1, 1'b1, ST_FULL,  16'h0000, 8'h00, 1'b0, 16);
    // head sits at the top track: exact hit, then neighbors, then a same-track tie
    add_row(MODE_DEQ, 16'h0000, 8'h00, 1'b0, 1'b0, ST_OK,    16'h0000, 8'h00, 1'b0, 0);
    add_row(MODE_DEQ, 16'hFFFF, 8'hFF, 1'b1, 1'b0, ST_OK,    16'h0000, 8'h00, 1'b0, 0);
    add_row(MODE_DEQ, 16'h0000, 8'h00, 1'b0, 1'b0, ST_OK,    16'h0000, 8'h00, 1'b0, 0);
    add_row(MODE_DEQ, 16'h5A5A, 8'hA5, 1'b1, 1'b0, ST_OK,    16'h0000, 8'h00, 1'b0, 0);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].pin, 0);
    end

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p % 3 != 1);
      case (p % 4)
        0: enq_pct = 80;
        1: enq_pct = 50;
        2: enq_pct = 25;
        default: enq_pct = 60;
      endcase
      base = TRACK_BITS'($urandom_range(0, (1 << TRACK_BITS) - 1));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 5) hold_len = HOLD_CYCLES;
        if (p == 5 && k == 20) wait (rsp_count == sent_count);
        c.mode  = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
        c.track = pick_track(base);
        c.tag   = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
        c.wr    = 1'($urandom_range(0, 1));
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        send_cmd(c, no_pin, gap);
      end
    end

    @(negedge clk);
    req_ch.valid = 1'b0;
    wait (rsp_count == sent_count);
    repeat (DRAIN_CYCLES) @(posedge clk);
    errors += due_rsp_q.size();

    $display("ran %0d commands: %0d enqueues (%0d dropped on full), %0d dequeues (%0d on empty)",
             sent_count, n_enq, n_full, n_deq, n_empty);
    $display("peak table occupancy %0d of %0d, %0d errors", peak_occ, QUEUE_DEPTH, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sstf_pkg.sv
hdl/sstf_ifs.sv
hdl/sstf_datapath.sv
hdl/sstf_ctrl.sv
hdl/sstf_disk_request_scheduler_core.sv
tb/tb.sv
